@@ rtl/lzwc_pkg.sv @@
// ----------------------------------------------------------------------------
// lzwc_pkg: shared types and constants of the LZW compressor
// Code widths, dictionary geometry, controller states and the write request
// that the controller sends to the row of dictionary cells.
// ----------------------------------------------------------------------------
package lzwc_pkg;

  localparam int CODE_BITS    = 12;
  localparam int DICT_ENTRIES = 4096;
  localparam int CODE_LIMIT   = (DICT_ENTRIES < (1 << CODE_BITS)) ?
                                DICT_ENTRIES : (1 << CODE_BITS);
  localparam int LIMIT_BITS   = $clog2(CODE_LIMIT);
  localparam int NEXT_W       = CODE_BITS + 1;
  localparam int FIRST_FREE   = 257;
  localparam int KEY_W        = CODE_BITS + 8;

  // Each cell holds a fixed slice of consecutive codes.
  localparam int CELL_IDX_BITS = 4;
  localparam int CELL_ENTRIES  = 1 << CELL_IDX_BITS;
  localparam int NUM_CELLS     = CODE_LIMIT / CELL_ENTRIES;
  localparam int CELL_SEL_BITS = LIMIT_BITS - CELL_IDX_BITS;

  // Cells are merged in groups before the final merge.
  localparam int GROUP_CELLS = 16;
  localparam int NUM_GROUPS  = NUM_CELLS / GROUP_CELLS;

  localparam int TDATA_W = ((CODE_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_RED1,
    ST_RED2,
    ST_DEC
  } ctrl_state_e;

  typedef struct packed {
    logic                  en;
    logic [LIMIT_BITS-1:0] code;
    logic [KEY_W-1:0]      key;
  } dict_wr_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic                 last;
  } out_item_t;

endpackage

@@ rtl/lzwc_cell.sv @@
// ----------------------------------------------------------------------------
// lzwc_cell: one slice of the dictionary
// Holds the (prefix, byte) keys of a fixed run of codes, compares them all
// against the broadcast search key and registers the code of the match.
// ----------------------------------------------------------------------------
module lzwc_cell (
  input  logic                                clk_i,
  input  logic [lzwc_pkg::CELL_SEL_BITS-1:0]  cell_idx_i,
  input  logic [lzwc_pkg::KEY_W-1:0]          key_i,
  input  logic [lzwc_pkg::NEXT_W-1:0]         next_free_i,
  input  lzwc_pkg::dict_wr_t                  wr_i,
  output logic [lzwc_pkg::CODE_BITS-1:0]      hit_o
);

  logic [lzwc_pkg::KEY_W-1:0]     ent_q [lzwc_pkg::CELL_ENTRIES];
  logic [lzwc_pkg::CODE_BITS-1:0] hit_d, hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.code[lzwc_pkg::LIMIT_BITS-1:lzwc_pkg::CELL_IDX_BITS] == cell_idx_i))
    begin
      ent_q[wr_i.code[lzwc_pkg::CELL_IDX_BITS-1:0]] <= wr_i.key;
    end
    hit_q <= hit_d;
  end

  // Only codes between the first learned code and the next free one are live;
  // keys are unique among live entries, so the matches can simply be ORed.
  always_comb begin
    logic [lzwc_pkg::LIMIT_BITS-1:0] code;
    logic [lzwc_pkg::NEXT_W-1:0]     code_x;
    hit_d = '0;
    for (int j = 0; j < lzwc_pkg::CELL_ENTRIES; j++) begin
      code   = {cell_idx_i, lzwc_pkg::CELL_IDX_BITS'(j)};
      code_x = lzwc_pkg::NEXT_W'(code);
      if ((code_x >= lzwc_pkg::NEXT_W'(lzwc_pkg::FIRST_FREE)) && (code_x < next_free_i)
          && (ent_q[j] == key_i)) begin
        hit_d = hit_d | lzwc_pkg::CODE_BITS'(code);
      end
    end
  end

  assign hit_o = hit_q;

endmodule

@@ rtl/lzw_compressor.sv @@
// ----------------------------------------------------------------------------
// lzw_compressor: streaming LZW encoder with a cell-row dictionary
// Accepts message bytes and emits dictionary codes, one message at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: s_axis_tdata_i carries one message byte, s_axis_tlast_i
//   marks the last byte of the message. Output stream: m_axis_tdata_o
//   carries a code word (bytes are 1..256, learned strings 257 up) and
//   m_axis_tlast_o marks the final code of the message.
//   The first byte of a message needs no search. Every further byte passes
//   through the accept, a compare in all dictionary cells at once,
//   a two-level registered merge of the cell results, then the decision.
//   A new byte is taken only after the decision on the previous one.
//   Codes are visible on the output the cycle after the decision; a byte
//   may yield up to two codes, held in a two-entry output buffer.
//   The decision waits while the buffer still holds codes, so a stalled
//   receiver holds back the input; no code is lost or repeated. The first
//   byte of a message is taken only once the buffer is empty.
//   Reset empties the dictionary and the buffer. The dictionary is also
//   emptied after each message; it stops growing when all codes are used.
// ----------------------------------------------------------------------------
module lzw_compressor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i,   // [7:0] data_byte
  input  logic                         s_axis_tlast_i,   // end_of_message
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [lzwc_pkg::TDATA_W-1:0] m_axis_tdata_o,   // [11:0] code_word
  output logic                         m_axis_tlast_o    // last_code
);

  lzwc_pkg::ctrl_state_e state_q, state_d;

  logic [lzwc_pkg::CODE_BITS-1:0] prefix_q, prefix_d;
  logic                           pvalid_q, pvalid_d;
  logic [lzwc_pkg::NEXT_W-1:0]    next_free_q, next_free_d;
  logic [lzwc_pkg::KEY_W-1:0]     key_q, key_d;
  logic [7:0]                     byte_q, byte_d;
  logic                           eom_q, eom_d;
  lzwc_pkg::out_item_t            out0_q, out0_d, out1_q, out1_d;
  logic [1:0]                     cnt_q, cnt_d;

  logic                           in_fire, out_fire;
  lzwc_pkg::dict_wr_t             wr;
  logic [lzwc_pkg::CODE_BITS-1:0] cell_hit [lzwc_pkg::NUM_CELLS];
  logic [lzwc_pkg::CODE_BITS-1:0] grp_q [lzwc_pkg::NUM_GROUPS];
  logic [lzwc_pkg::CODE_BITS-1:0] hit_q, hit_d;

  // A first byte may emit a code at once, so it needs an empty buffer.
  assign s_axis_tready_o = (state_q == lzwc_pkg::ST_IDLE) && ((cnt_q == 2'd0) || pvalid_q);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign out_fire        = m_axis_tvalid_o && m_axis_tready_i;
  assign m_axis_tdata_o  = lzwc_pkg::TDATA_W'(out0_q.code);
  assign m_axis_tlast_o  = out0_q.last;

  // Row of dictionary cells.
  for (genvar g = 0; g < lzwc_pkg::NUM_CELLS; g++) begin : g_cell
    lzwc_cell u_cell (
      .clk_i       (clk_i),
      .cell_idx_i  (lzwc_pkg::CELL_SEL_BITS'(g)),
      .key_i       (key_q),
      .next_free_i (next_free_q),
      .wr_i        (wr),
      .hit_o       (cell_hit[g])
    );
  end

  // Registered merge of the cell results: groups first, then the groups.
  for (genvar g = 0; g < lzwc_pkg::NUM_GROUPS; g++) begin : g_grp
    logic [lzwc_pkg::CODE_BITS-1:0] grp_d;
    always_comb begin
      grp_d = '0;
      for (int c = 0; c < lzwc_pkg::GROUP_CELLS; c++) begin
        grp_d = grp_d | cell_hit[g * lzwc_pkg::GROUP_CELLS + c];
      end
    end
    always_ff @(posedge clk_i) begin
      grp_q[g] <= grp_d;
    end
  end

  always_comb begin
    hit_d = '0;
    for (int g = 0; g < lzwc_pkg::NUM_GROUPS; g++) begin
      hit_d = hit_d | grp_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lzwc_pkg::ST_IDLE: if (in_fire && pvalid_q) state_d = lzwc_pkg::ST_CMP;
      lzwc_pkg::ST_CMP:  state_d = lzwc_pkg::ST_RED1;
      lzwc_pkg::ST_RED1: state_d = lzwc_pkg::ST_RED2;
      lzwc_pkg::ST_RED2: state_d = lzwc_pkg::ST_DEC;
      lzwc_pkg::ST_DEC:  if (cnt_q == 2'd0) state_d = lzwc_pkg::ST_IDLE;
      default:           state_d = lzwc_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs. Codes are pushed only while the buffer is empty.
  always_comb begin
    logic [lzwc_pkg::CODE_BITS-1:0] cur;
    logic                           push0, push1;
    lzwc_pkg::out_item_t            item0, item1;
    prefix_d    = prefix_q;
    pvalid_d    = pvalid_q;
    next_free_d = next_free_q;
    key_d       = key_q;
    byte_d      = byte_q;
    eom_d       = eom_q;
    wr          = '0;
    push0       = 1'b0;
    push1       = 1'b0;
    item0       = '0;
    item1       = '0;
    cur         = prefix_q;
    case (state_q)
      lzwc_pkg::ST_IDLE: begin
        if (in_fire) begin
          byte_d = s_axis_tdata_i;
          eom_d  = s_axis_tlast_i;
          key_d  = {prefix_q, s_axis_tdata_i};
          if (!pvalid_q) begin
            cur = lzwc_pkg::CODE_BITS'({1'b0, s_axis_tdata_i} + 9'd1);
            if (s_axis_tlast_i) begin
              push0       = 1'b1;
              item0       = '{code: cur, last: 1'b1};
              prefix_d    = '0;
              pvalid_d    = 1'b0;
              next_free_d = lzwc_pkg::NEXT_W'(lzwc_pkg::FIRST_FREE);
            end else begin
              prefix_d = cur;
              pvalid_d = 1'b1;
            end
          end
        end
      end
      lzwc_pkg::ST_DEC: begin
        // The decision is held until the previous codes have drained.
        if (cnt_q == 2'd0) begin
          if (hit_q != '0) begin
            cur = hit_q;
          end else begin
            push0 = 1'b1;
            item0 = '{code: prefix_q, last: 1'b0};
            if (next_free_q < lzwc_pkg::NEXT_W'(lzwc_pkg::CODE_LIMIT)) begin
              wr.en       = 1'b1;
              wr.code     = next_free_q[lzwc_pkg::LIMIT_BITS-1:0];
              wr.key      = key_q;
              next_free_d = next_free_q + 1'b1;
            end
            cur = lzwc_pkg::CODE_BITS'({1'b0, byte_q} + 9'd1);
          end
          if (eom_q) begin
            if (push0) begin
              push1 = 1'b1;
              item1 = '{code: cur, last: 1'b1};
            end else begin
              push0 = 1'b1;
              item0 = '{code: cur, last: 1'b1};
            end
            prefix_d    = '0;
            pvalid_d    = 1'b0;
            next_free_d = lzwc_pkg::NEXT_W'(lzwc_pkg::FIRST_FREE);
          end else begin
            prefix_d = cur;
          end
        end
      end
      default: ;
    endcase

    out0_d = out0_q;
    out1_d = out1_q;
    cnt_d  = cnt_q;
    if (push0) begin
      out0_d = item0;
      out1_d = item1;
      cnt_d  = push1 ? 2'd2 : 2'd1;
    end else if (out_fire) begin
      out0_d = out1_q;
      cnt_d  = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lzwc_pkg::ST_IDLE;
      prefix_q    <= '0;
      pvalid_q    <= 1'b0;
      next_free_q <= lzwc_pkg::NEXT_W'(lzwc_pkg::FIRST_FREE);
      cnt_q       <= 2'd0;
    end else begin
      state_q     <= state_d;
      prefix_q    <= prefix_d;
      pvalid_q    <= pvalid_d;
      next_free_q <= next_free_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    byte_q <= byte_d;
    eom_q  <= eom_d;
    out0_q <= out0_d;
    out1_q <= out1_d;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("output buffer count out of range");

  a_dec_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == lzwc_pkg::ST_DEC) && (cnt_q != 2'd0)) |=>
    (state_q == lzwc_pkg::ST_DEC))
    else $error("decision taken while codes are buffered");

  a_hit_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == lzwc_pkg::ST_DEC) && (hit_q != '0)) |->
    ((lzwc_pkg::NEXT_W'(hit_q) >= lzwc_pkg::NEXT_W'(lzwc_pkg::FIRST_FREE)) &&
     (lzwc_pkg::NEXT_W'(hit_q) < next_free_q)))
    else $error("dictionary hit outside the live codes");

  a_search_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lzwc_pkg::ST_CMP) |-> ##3 (state_q == lzwc_pkg::ST_DEC))
    else $error("search pipeline out of step");
`endif

endmodule

@@ tb/lzw_compressor_test.sv @@
// ----------------------------------------------------------------------------
// lzw_compressor_test: self-checking bench for the LZW compressor
// Byte messages go in over the input stream with random gaps. A behavioral
// encoder or the directed rows give each code word and last flag, which are
// compared against the output stream while the receiver stalls at random.
// ----------------------------------------------------------------------------
module lzw_compressor_test;

  typedef struct packed {
    logic [lzwc_pkg::CODE_BITS-1:0] code;
    logic                           last;
  } code_exp_t;

  typedef struct {
    logic [7:0] data;
    logic       eom;
    logic       chk;   // 1 when the expected codes below are typed in
    int         n;
    logic [lzwc_pkg::CODE_BITS-1:0] c0;
    logic       l0;
    logic [lzwc_pkg::CODE_BITS-1:0] c1;
    logic       l1;
  } row_t;

  localparam int MAX_CYCLES = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = '0;
  logic s_axis_tlast_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [lzwc_pkg::TDATA_W-1:0] m_axis_tdata_o;
  logic m_axis_tlast_o;

  lzw_compressor dut (.*);

  always #5 clk_i = ~clk_i;

  // Encoder state mirrored by the predictor.
  logic [lzwc_pkg::CODE_BITS-1:0] enc_prefix;
  logic                           enc_active;
  int                             enc_next;
  logic [lzwc_pkg::KEY_W-1:0]     enc_dict [lzwc_pkg::CODE_LIMIT];

  code_exp_t code_queue[$];
  int        err_cnt = 0;
  int        cycle_cnt = 0;
  bit        stim_done = 1'b0;

  function automatic void encode_byte(input logic [7:0] b, input logic eom);
    int hit;
    logic [lzwc_pkg::KEY_W-1:0] key;
    hit = 0;
    if (!enc_active) begin
      enc_prefix = lzwc_pkg::CODE_BITS'(32'(b) + 1);
      enc_active = 1'b1;
    end else begin
      key = {enc_prefix, b};
      for (int k = lzwc_pkg::FIRST_FREE; k < enc_next; k++)
        if (hit == 0 && enc_dict[k] == key) hit = k;
      if (hit != 0) begin
        enc_prefix = lzwc_pkg::CODE_BITS'(hit);
      end else begin
        code_queue.push_back('{code: enc_prefix, last: 1'b0});
        if (enc_next < lzwc_pkg::CODE_LIMIT) begin
          enc_dict[enc_next] = key;
          enc_next++;
        end
        enc_prefix = lzwc_pkg::CODE_BITS'(32'(b) + 1);
      end
    end
    if (eom) begin
      code_queue.push_back('{code: enc_prefix, last: 1'b1});
      enc_prefix = '0;
      enc_active = 1'b0;
      enc_next   = lzwc_pkg::FIRST_FREE;
    end
  endfunction

  // Directed part: one-byte messages at the extremes, a repeating run that
  // builds and hits learned strings, a two-byte and a three-byte message.
  row_t dir_rows[] = '{
    '{8'h00, 1'b1, 1'b1, 1, 12'd1,   1'b1, 12'd0, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 1, 12'd256, 1'b1, 12'd0, 1'b0},
    '{8'h41, 1'b0, 1'b1, 0, 12'd0,   1'b0, 12'd0, 1'b0},
    '{8'h41, 1'b0, 1'b0, 0, 12'd0,   1'b0, 12'd0, 1'b0},
    '{8'h41, 1'b0, 1'b0, 0, 12'd0,   1'b0, 12'd0, 1'b0},
    '{8'h41, 1'b0, 1'b0, 0, 12'd0,   1'b0, 12'd0, 1'b0},
    '{8'h41, 1'b0, 1'b0, 0, 12'd0,   1'b0, 12'd0, 1'b0},
    '{8'h41, 1'b0, 1'b0, 0, 12'd0,   1'b0, 12'd0, 1'b0},
    '{8'h42, 1'b1, 1'b0, 0, 12'd0,   1'b0, 12'd0, 1'b0},
    '{8'hAA, 1'b0, 1'b0, 0, 12'd0,   1'b0, 12'd0, 1'b0},
    '{8'h55, 1'b1, 1'b1, 2, 12'd171, 1'b0, 12'd86, 1'b1},
    '{8'h12, 1'b0, 1'b0, 0, 12'd0,   1'b0, 12'd0, 1'b0},
    '{8'h12, 1'b0, 1'b0, 0, 12'd0,   1'b0, 12'd0, 1'b0},
    '{8'h12, 1'b1, 1'b0, 0, 12'd0,   1'b0, 12'd0, 1'b0}
  };

  // Valid stays high across back-to-back requests; it drops only for a gap.
  task automatic send_byte(input logic [7:0] b, input logic eom);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= eom;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  function automatic logic [7:0] pick_byte(input int alpha);
    if (alpha == 0) return 8'($urandom);
    return 8'($urandom_range(0, alpha - 1));
  endfunction

  initial begin
    int len, alpha, mode;
    enc_prefix = '0;
    enc_active = 1'b0;
    enc_next   = lzwc_pkg::FIRST_FREE;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].chk) begin
        if (dir_rows[i].n >= 1)
          code_queue.push_back('{code: dir_rows[i].c0, last: dir_rows[i].l0});
        if (dir_rows[i].n == 2)
          code_queue.push_back('{code: dir_rows[i].c1, last: dir_rows[i].l1});
        // Keep the mirror in step without queueing a second copy.
        if (dir_rows[i].eom) begin
          enc_active = 1'b0;
          enc_next   = lzwc_pkg::FIRST_FREE;
        end else begin
          enc_prefix = lzwc_pkg::CODE_BITS'(32'(dir_rows[i].data) + 1);
          enc_active = 1'b1;
        end
      end else begin
        encode_byte(dir_rows[i].data, dir_rows[i].eom);
      end
      send_byte(dir_rows[i].data, dir_rows[i].eom);
    end
    // Random messages: mostly small alphabets so strings repeat; now and
    // then a longer message over two symbols builds long learned strings.
    for (int sent = 0; sent < 1600; ) begin
      mode = $urandom_range(0, 19);
      if (mode == 0) begin
        len = $urandom_range(100, 300); alpha = 2;
      end else begin
        len = $urandom_range(1, 40);
        alpha = (mode < 4) ? 0 : $urandom_range(1, 8);
      end
      for (int j = 0; j < len; j++) begin
        logic [7:0] b;
        b = pick_byte(alpha);
        if ($urandom_range(0, 15) == 0) b = 8'hFF;
        encode_byte(b, j == len - 1);
        send_byte(b, j == len - 1);
      end
      sent += len;
    end
    s_axis_tvalid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: after each accepted code, ready may drop for a random stall.
  initial begin
    int gap;
    forever begin
      @(posedge clk_i);
      if (m_axis_tready_i && m_axis_tvalid_o) begin
        gap = $urandom_range(0, 9);
        if (gap > 0) begin
          m_axis_tready_i <= 1'b0;
          repeat (gap - 1) @(posedge clk_i);
          @(posedge clk_i);
          m_axis_tready_i <= 1'b1;
        end
      end else if (!m_axis_tready_i && rst_ni) begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    code_exp_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (code_queue.size() == 0) begin
        $error("unexpected code_word %0d", m_axis_tdata_o[lzwc_pkg::CODE_BITS-1:0]);
        err_cnt++;
      end else begin
        want = code_queue.pop_front();
        if (m_axis_tdata_o[lzwc_pkg::CODE_BITS-1:0] !== want.code) begin
          $error("code_word: expected %0d, got %0d", want.code,
                 m_axis_tdata_o[lzwc_pkg::CODE_BITS-1:0]);
          err_cnt++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last_code: expected %0b, got %0b", want.last, m_axis_tlast_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > MAX_CYCLES) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    while (code_queue.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0 && code_queue.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/lzwc_pkg.sv
rtl/lzwc_cell.sv
rtl/lzw_compressor.sv
tb/lzw_compressor_test.sv
